// ===== rtl/gfgs_pkg.sv =====
// Shared types, widths and helpers for the ground-follow gravity step block.
`default_nettype none

package gfgs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DT_W     = 16;
    localparam int unsigned GRAV_W   = 31;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_REACH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ACCEL = 2'd2;

    typedef struct packed {
        logic signed [WORD_W-1:0] hit_height;
        logic                     hit_present;
        logic                     frame_last;
        logic [DT_W-1:0]          frame_dt;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] height_adjust;
        logic signed [WORD_W-1:0] airborne_now;
        logic signed [WORD_W-1:0] landing_speed;
        logic signed [WORD_W-1:0] speed_now;
        logic                     on_ground;
        logic                     ground_found;
    } out_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic acc;      // fold accepted word into frame accumulators
        logic mul1;     // ground pick, dt products
        logic mul2;     // g*dt*dt product, speed update
        logic ga;       // gravity displacement
        logic fin;      // commit state and load result
    } cmd_t;

    function automatic logic signed [WORD_W-1:0] sat36(input logic signed [35:0] x);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (x > hi)
            return 32'sh7FFFFFFF;
        else if (x < lo)
            return 32'sh80000000;
        else
            return x[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gfgs_in_if.sv =====
// Input channel: one probe-hit word per handshake.
`default_nettype none

interface gfgs_in_if;
    logic               valid;
    logic               ready;
    gfgs_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gfgs_out_if.sv =====
// Output channel: one frame result word per handshake.
`default_nettype none

interface gfgs_out_if;
    logic                valid;
    logic                ready;
    gfgs_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ground_follow_gravity_step_top.sv =====
// Ground-follow gravity step: the frame-last word passes accept, three
// multiply/subtract stages (chained dt*dt then g*dt*dt multiplies) and commit,
// which waits for a free result slot; result valid the cycle after commit.
// Throughput: one hit word per cycle while idle, none until a frame-last commits.
// Reset (async, active low): config to defaults, accumulators and speed state
// to zero, no result pending.
`default_nettype none

module ground_follow_gravity_step_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gfgs_in_if.sink                             hit,
    gfgs_out_if.source                          result,
    input  wire logic                           cfg_we,
    input  wire logic [gfgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gfgs_pkg::WORD_W-1:0]    cfg_data
);

    gfgs_pkg::cmd_t cmd;

    gfgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hit.valid),
        .in_last   (hit.data.frame_last),
        .in_ready  (hit.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    gfgs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (hit.data),
        .out_data  (result.data)
    );

endmodule

`default_nettype wire

// ===== rtl/gfgs_ctrl.sv =====
// Sequencer for frame accumulation and the frame-final gravity step.
`default_nettype none

module gfgs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output gfgs_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_GA   = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.acc  = accept;
        cmd.mul1 = (state_reg == ST_MUL1);
        cmd.mul2 = (state_reg == ST_MUL2);
        cmd.ga   = (state_reg == ST_GA);
        cmd.fin  = (state_reg == ST_FIN) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_last)
                    state_next = ST_MUL1;
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_GA;
            ST_GA:   state_next = ST_FIN;
            ST_FIN:
            begin
                // hold until the result register can take the new word
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.fin)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gfgs_datapath.sv =====
// Datapath: config registers, frame accumulators, multiply stages, step state.
`default_nettype none

module gfgs_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire gfgs_pkg::cmd_t                     cmd,
    input  wire logic                               cfg_we,
    input  wire logic [gfgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gfgs_pkg::WORD_W-1:0]        cfg_data,
    input  wire gfgs_pkg::in_word_t                 in_data,
    output gfgs_pkg::out_word_t                     out_data
);

    localparam longint THRESH_FULL = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic signed [32:0] THRESH = 33'(THRESH_FULL);
    localparam longint GRAV_FULL = ((64'd32174 << FRAC_BITS) + 64'd999) / 64'd1000;
    localparam logic [30:0] GRAV_RESET =
        (GRAV_FULL > 64'h7FFFFFFF) ? 31'h7FFFFFFF : 31'(GRAV_FULL);
    localparam logic signed [31:0] REACH_RESET = 32'(64'd1 << FRAC_BITS);

    // configuration
    logic signed [31:0] offset_reg;
    logic signed [31:0] reach_reg;
    logic [30:0]        grav_reg;

    // frame accumulators
    logic signed [31:0] best_reg, best_next;
    logic               have_valid_reg, have_valid_next;
    logic signed [31:0] lowest_reg, lowest_next;
    logic               have_any_reg, have_any_next;

    // step state
    logic signed [31:0] speed_reg, speed_next;
    logic signed [31:0] hag_reg, hag_next;
    logic signed [31:0] impact_reg, impact_next;

    // pipeline payload
    logic [15:0]        dt_reg;
    logic signed [32:0] adj_reg;
    logic               step_reg;
    logic [31:0]        dtsq_reg;
    logic signed [48:0] vdt_reg;
    logic [46:0]        gdt_reg;
    logic [62:0]        gdtsq_reg;
    logic signed [32:0] term1_reg;
    logic signed [31:0] vnew_reg;
    logic signed [33:0] ga_reg;

    gfgs_pkg::out_word_t out_reg;

    // accumulate
    logic signed [32:0] limit;
    logic signed [32:0] h_ext;
    logic               h_valid;

    always_comb
    begin
        limit   = 33'(offset_reg) + 33'(reach_reg);
        h_ext   = 33'(in_data.hit_height);
        h_valid = h_ext < limit;

        best_next       = best_reg;
        have_valid_next = have_valid_reg;
        lowest_next     = lowest_reg;
        have_any_next   = have_any_reg;
        if (cmd.acc && in_data.hit_present)
        begin
            if (h_valid)
            begin
                if (!have_valid_reg || in_data.hit_height > best_reg)
                    best_next = in_data.hit_height;
                have_valid_next = 1'b1;
            end
            if (!have_any_reg || in_data.hit_height < lowest_reg)
                lowest_next = in_data.hit_height;
            have_any_next = 1'b1;
        end
        if (cmd.fin)
        begin
            best_next       = '0;
            have_valid_next = 1'b0;
            lowest_next     = '0;
            have_any_next   = 1'b0;
        end
    end

    // stage 1: ground pick and the dt products
    logic signed [31:0] ground;
    logic signed [32:0] adj_calc;
    logic               step_calc;

    always_comb
    begin
        priority if (have_valid_reg)
            ground = best_reg;
        else if (have_any_reg)
            ground = lowest_reg;
        else
            ground = '0;
        adj_calc  = 33'(ground) + 33'(offset_reg);
        step_calc = (speed_reg > 32'sd0) || (adj_calc > THRESH) || (adj_calc < -THRESH);
    end

    // stage 2: speed update
    logic [30:0]        dv;
    logic signed [35:0] vdiff;

    always_comb
    begin
        dv    = gdt_reg[46:16];
        vdiff = 36'(speed_reg) - 36'($signed({1'b0, dv}));
    end

    // stage 3 inputs
    logic [29:0] term2;
    assign term2 = gdtsq_reg[62:33];

    // final step
    logic signed [33:0] ga_pos;
    logic signed [34:0] adj_new;
    logic signed [35:0] hag_full;
    logic signed [31:0] hag_sat;
    logic signed [31:0] adj_out;
    logic               land;

    always_comb
    begin
        ga_pos = (ga_reg > 34'sd0) ? ga_reg : '0;
        if (adj_reg > 33'sd0)
            adj_new = 35'(adj_reg) + 35'(ga_pos);
        else if (34'(adj_reg) > ga_reg)
            adj_new = 35'(adj_reg);
        else
            adj_new = 35'(ga_reg);
        hag_full = 36'(adj_new) - 36'(adj_reg);
        hag_sat  = gfgs_pkg::sat36(hag_full);
        land     = (33'(hag_sat) < THRESH) && (33'(vnew_reg) < THRESH);

        speed_next  = speed_reg;
        hag_next    = hag_reg;
        impact_next = impact_reg;
        adj_out     = '0;
        if (cmd.fin)
        begin
            if (step_reg)
            begin
                adj_out = gfgs_pkg::sat36(36'(adj_new));
                if (land)
                begin
                    impact_next = vnew_reg;
                    speed_next  = '0;
                    hag_next    = '0;
                end
                else
                begin
                    speed_next = vnew_reg;
                    hag_next   = hag_sat;
                end
            end
            else
            begin
                speed_next = '0;
                hag_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            reach_reg      <= REACH_RESET;
            grav_reg       <= GRAV_RESET;
            best_reg       <= '0;
            have_valid_reg <= 1'b0;
            lowest_reg     <= '0;
            have_any_reg   <= 1'b0;
            speed_reg      <= '0;
            hag_reg        <= '0;
            impact_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gfgs_pkg::REG_PROBE_OFFSET:  offset_reg <= cfg_data;
                    gfgs_pkg::REG_PROBE_REACH:   reach_reg  <= cfg_data;
                    gfgs_pkg::REG_GRAVITY_ACCEL: grav_reg   <= cfg_data[30:0];
                    default: ;
                endcase
            end
            best_reg       <= best_next;
            have_valid_reg <= have_valid_next;
            lowest_reg     <= lowest_next;
            have_any_reg   <= have_any_next;
            speed_reg      <= speed_next;
            hag_reg        <= hag_next;
            impact_reg     <= impact_next;
        end
    end

    // payload pipeline, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.acc && in_data.frame_last)
            dt_reg <= in_data.frame_dt;
        if (cmd.mul1)
        begin
            adj_reg  <= adj_calc;
            step_reg <= step_calc;
            dtsq_reg <= 32'(dt_reg) * 32'(dt_reg);
            vdt_reg  <= 49'(speed_reg) * 49'($signed({1'b0, dt_reg}));
            gdt_reg  <= 47'(grav_reg) * 47'(dt_reg);
        end
        if (cmd.mul2)
        begin
            gdtsq_reg <= 63'(grav_reg) * 63'(dtsq_reg);
            term1_reg <= 33'(vdt_reg >>> 16);
            vnew_reg  <= gfgs_pkg::sat36(vdiff);
        end
        if (cmd.ga)
            ga_reg <= 34'(term1_reg) - 34'($signed({1'b0, term2}));
        if (cmd.fin)
        begin
            out_reg.height_adjust <= adj_out;
            out_reg.airborne_now  <= hag_next;
            out_reg.landing_speed <= impact_next;
            out_reg.speed_now     <= speed_next;
            out_reg.on_ground     <= (speed_next == 32'sd0) && (hag_next == 32'sd0);
            out_reg.ground_found  <= have_any_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== test/tb_ground_follow_gravity_step_top.sv =====
// Testbench for ground_follow_gravity_step_top: directed and random hit frames.

module tb_ground_follow_gravity_step_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC         = 16;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam longint SETTLE_THR   = ((longint'(1) << FRAC) + 500) / 1000;
    localparam longint GRAV_DEFAULT = ((longint'(32174) << FRAC) + 999) / 1000;
    localparam int     PHASE_ITEMS  = 285;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [gfgs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gfgs_pkg::WORD_W-1:0] cfg_data;

    gfgs_in_if  hit_if ();
    gfgs_out_if res_if ();

    ground_follow_gravity_step_top #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .hit(hit_if),
        .result(res_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted state and register copies
    longint          probe_offset_v;
    longint          probe_reach_v;
    longint unsigned gravity_v;
    longint          best_valid_h;
    bit              valid_seen;
    longint          lowest_h;
    bit              any_seen;
    longint          speed_v;
    longint          airborne_h;
    longint          impact_v;

    gfgs_pkg::out_word_t expected_frames[$];
    int        error_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > S32_MAX)
            return 32'sh7FFFFFFF;
        if (x < S32_MIN)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic gfgs_pkg::in_word_t hit_word(input longint h, input bit present,
                                                    input bit last, input int unsigned dt);
        gfgs_pkg::in_word_t w;
        w.hit_height  = clamp32(h);
        w.hit_present = present;
        w.frame_last  = last;
        w.frame_dt    = dt[15:0];
        return w;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // fold one accepted hit word; on the frame-last word run the gravity step
    task automatic advance_ground_step(input gfgs_pkg::in_word_t w);
        longint h, gnd, adj, adj_new, term1, term2, ga, dv, v;
        longint unsigned dt_u, g_u;
        gfgs_pkg::out_word_t res;
        h = longint'($signed(w.hit_height));
        if (w.hit_present)
        begin
            if (h < probe_offset_v + probe_reach_v)
            begin
                if (!valid_seen || h > best_valid_h)
                    best_valid_h = h;
                valid_seen = 1'b1;
            end
            if (!any_seen || h < lowest_h)
                lowest_h = h;
            any_seen = 1'b1;
        end
        if (!w.frame_last)
            return;

        gnd = valid_seen ? best_valid_h : (any_seen ? lowest_h : 0);
        adj = gnd + probe_offset_v;
        adj_new = 0;
        if (speed_v > 0 || adj > SETTLE_THR || adj < -SETTLE_THR)
        begin
            v     = speed_v;
            dt_u  = 64'(w.frame_dt);
            g_u   = gravity_v;
            term1 = (v * longint'(dt_u)) >>> 16;
            term2 = longint'((g_u * (dt_u * dt_u)) >> 33);
            ga    = term1 - term2;
            dv    = longint'((g_u * dt_u) >> 16);
            if (adj > 0)
                adj_new = adj + ((ga > 0) ? ga : 0);
            else
                adj_new = (adj > ga) ? adj : ga;
            speed_v    = longint'(clamp32(v - dv));
            airborne_h = longint'(clamp32(adj_new - adj));
            // landed: latch the impact speed
            if (airborne_h < SETTLE_THR && speed_v < SETTLE_THR)
            begin
                impact_v   = speed_v;
                speed_v    = 0;
                airborne_h = 0;
            end
        end
        else
        begin
            speed_v    = 0;
            airborne_h = 0;
        end

        res.height_adjust = clamp32(adj_new);
        res.airborne_now  = airborne_h[31:0];
        res.landing_speed = impact_v[31:0];
        res.speed_now     = speed_v[31:0];
        res.on_ground     = (speed_v == 0 && airborne_h == 0);
        res.ground_found  = any_seen;
        expected_frames = {expected_frames, res};

        best_valid_h = 0;
        valid_seen   = 1'b0;
        lowest_h     = 0;
        any_seen     = 1'b0;
    endtask

    task automatic check_result(input gfgs_pkg::out_word_t got);
        gfgs_pkg::out_word_t want;
        if (expected_frames.size() == 0)
        begin
            report_error("result word with no frame pending");
            return;
        end
        want = expected_frames.pop_front();
        if (got.height_adjust !== want.height_adjust)
            report_error($sformatf("height_adjust got %0d expected %0d",
                                   got.height_adjust, want.height_adjust));
        if (got.airborne_now !== want.airborne_now)
            report_error($sformatf("airborne_now got %0d expected %0d",
                                   got.airborne_now, want.airborne_now));
        if (got.landing_speed !== want.landing_speed)
            report_error($sformatf("landing_speed got %0d expected %0d",
                                   got.landing_speed, want.landing_speed));
        if (got.speed_now !== want.speed_now)
            report_error($sformatf("speed_now got %0d expected %0d",
                                   got.speed_now, want.speed_now));
        if (got.on_ground !== want.on_ground)
            report_error($sformatf("on_ground got %b expected %b",
                                   got.on_ground, want.on_ground));
        if (got.ground_found !== want.ground_found)
            report_error($sformatf("ground_found got %b expected %b",
                                   got.ground_found, want.ground_found));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_result(res_if.data);
    end

    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_hit(input gfgs_pkg::in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            hit_if.valid <= 1'b0;
            @(posedge clk);
        end
        hit_if.valid <= 1'b1;
        hit_if.data  <= w;
        @(posedge clk);
        while (!hit_if.ready)
            @(posedge clk);
        advance_ground_step(w);
    endtask

    // non-last words give no result, so allow the pipeline to empty as well
    task automatic wait_idle();
        hit_if.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] offset, input logic [31:0] reach,
                              input logic [30:0] grav);
        cfg_we    <= 1'b1;
        cfg_index <= gfgs_pkg::REG_PROBE_OFFSET;
        cfg_data  <= offset;
        @(posedge clk);
        cfg_index <= gfgs_pkg::REG_PROBE_REACH;
        cfg_data  <= reach;
        @(posedge clk);
        cfg_index <= gfgs_pkg::REG_GRAVITY_ACCEL;
        cfg_data  <= {1'b0, grav};
        @(posedge clk);
        cfg_we <= 1'b0;
        probe_offset_v = longint'($signed(offset));
        probe_reach_v  = longint'($signed(reach));
        gravity_v      = 64'(grav);
    endtask

    task automatic test_frames_without_hits();
        send_hit(hit_word(S32_MAX, 1'b0, 1'b0, 65535));
        send_hit(hit_word(S32_MIN, 1'b0, 1'b1, 1000));
    endtask

    task automatic test_extreme_heights();
        // lowest valid hit at the floor of the range, dt at its top
        send_hit(hit_word(S32_MIN, 1'b1, 1'b0, 0));
        send_hit(hit_word(S32_MAX, 1'b1, 1'b0, 65535));
        send_hit(hit_word(0, 1'b0, 1'b1, 65535));
        // no valid hit: falls back to the lowest one
        send_hit(hit_word(64'sd65536, 1'b1, 1'b0, 0));
        send_hit(hit_word(64'sh7FFF0000, 1'b1, 1'b0, 0));
        send_hit(hit_word(64'sd131072, 1'b1, 1'b1, 500));
    endtask

    task automatic test_settle_threshold();
        send_hit(hit_word(SETTLE_THR, 1'b1, 1'b1, 100));
        send_hit(hit_word(SETTLE_THR + 1, 1'b1, 1'b1, 100));
        send_hit(hit_word(-SETTLE_THR, 1'b1, 1'b1, 100));
        send_hit(hit_word(-SETTLE_THR - 1, 1'b1, 1'b1, 0));
    endtask

    task automatic test_fall_and_land();
        repeat (5) send_hit(hit_word(-64'sd3276800, 1'b1, 1'b1, 1092));
        send_hit(hit_word(-64'sd65536, 1'b1, 1'b1, 65535));
    endtask

    task automatic test_random_frames(input int n_items, input int send_pct, input int stall_pct);
        int     sent;
        int     len;
        int     kind;
        int     jit;
        longint base;
        longint h;
        bit     present;
        int     dt;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            len  = $urandom_range(1, 6);
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                // ground well below: avatar falls
                base = -probe_offset_v - longint'($urandom_range(32'h10000, 32'hC80000));
                jit  = 32768;
            end
            else if (kind <= 5)
            begin
                base = -probe_offset_v;
                jit  = 100;
            end
            else
            begin
                base = -probe_offset_v + longint'($urandom_range(1, 32'h40000));
                jit  = 65536;
            end
            for (int i = 0; i < len; i++)
            begin
                h = base + longint'($urandom_range(0, 2 * jit)) - longint'(jit);
                if (kind == 8 || $urandom_range(0, 9) == 0)
                    h = longint'($signed($urandom()));
                present = (kind != 9) && ($urandom_range(0, 99) < 85);
                dt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(200, 3000);
                send_hit(hit_word(h, present, i == len - 1, dt));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        hit_if.valid   = 1'b0;
        hit_if.data    = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        probe_offset_v = 0;
        probe_reach_v  = longint'(1) << FRAC;
        gravity_v      = GRAV_DEFAULT;
        best_valid_h   = 0;
        valid_seen     = 1'b0;
        lowest_h       = 0;
        any_seen       = 1'b0;
        speed_v        = 0;
        airborne_h     = 0;
        impact_v       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frames_without_hits();
        test_extreme_heights();
        test_settle_threshold();
        test_fall_and_land();
        wait_idle();

        set_config(32'sd196608, 32'sd65536, 31'd2108556);
        test_random_frames(PHASE_ITEMS, 0, 0);
        wait_idle();

        set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
        test_random_frames(PHASE_ITEMS, 83, 0);
        wait_idle();

        set_config(32'h80000000, 32'h80000000, 31'd0);
        test_random_frames(PHASE_ITEMS, 0, 83);
        wait_idle();

        set_config($urandom_range(0, 32'h40000), $urandom(),
                   31'($urandom_range(600000, 4200000)));
        test_random_frames(PHASE_ITEMS, 22, 22);
        wait_idle();

        if (error_count == 0)
            $display("ground_follow_gravity_step_top test passed");
        else
            $display("ground_follow_gravity_step_top test failed");
        $finish;
    end

    initial
    begin
        #6ms;
        $display("ground_follow_gravity_step_top test failed");
        $finish;
    end

endmodule
